/* hdl/smstk_pkg.sv */
// Package for the sorted minimum store: word types, operation codes and defaults.
// Used by smstk_cell and sorted_min_stack; depends on nothing else.
`default_nettype none

package smstk_pkg;

    // Default number of held values
    localparam int DEPTH_DEFAULT = 16;

    localparam int VALUE_W = 32;

    // Operation codes carried in func (code three acts as a peek)
    localparam logic [1:0] FUNC_PUSH = 2'd0;
    localparam logic [1:0] FUNC_POP  = 2'd1;
    localparam logic [1:0] FUNC_PEEK = 2'd2;

    // Top value reported when nothing is held
    localparam logic signed [VALUE_W-1:0] EMPTY_TOP = -32'sd1;

    // Request word
    typedef struct packed {
        logic [1:0]                func;
        logic signed [VALUE_W-1:0] value;
    } req_t;

    // Response word
    typedef struct packed {
        logic signed [VALUE_W-1:0] top_value;
        logic                      is_empty;
        logic                      refused;
    } rsp_t;

    // Command broadcast to every cell of the row
    typedef struct packed {
        logic                      push;
        logic                      pop;
        logic signed [VALUE_W-1:0] value;
    } cell_cmd_t;

endpackage

`default_nettype wire

/* hdl/smstk_cell.sv */
// One compare-and-shift cell of the sorted row: holds one value.
// Depends on smstk_pkg for the command type.
`default_nettype none

module smstk_cell (
    input  wire logic                                      clk,
    input  wire smstk_pkg::cell_cmd_t                      cmd,
    input  wire logic                                      occupied,
    input  wire logic                                      left_keep,
    input  wire logic signed [smstk_pkg::VALUE_W-1:0]      left_value,
    input  wire logic signed [smstk_pkg::VALUE_W-1:0]      right_value,
    output logic                                           keep,
    output logic signed [smstk_pkg::VALUE_W-1:0]           value,
    output logic signed [smstk_pkg::VALUE_W-1:0]           value_next
);

    logic signed [smstk_pkg::VALUE_W-1:0] value_reg;

    // Held value of an occupied cell stays put on a push when it is no larger than the new one
    assign keep = occupied && (value_reg <= cmd.value);

    // Push: keep, take the new value at the insertion point, or shift right.
    // Pop: take the right neighbour's value.
    always_comb
    begin
        value_next = value_reg;
        if (cmd.push)
        begin
            if (keep)
                value_next = value_reg;
            else if (left_keep)
                value_next = cmd.value;
            else
                value_next = left_value;
        end
        else if (cmd.pop)
        begin
            value_next = right_value;
        end
    end

    // Payload register, no reset needed
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

`default_nettype wire

/* hdl/sorted_min_stack.sv */
// Sorted minimum store of signed 32-bit values: top level, a row of smstk_cell.
// Depends on smstk_pkg and smstk_cell.
//
// Usage:
//   The req channel takes one word per operation: func selects push (insert
//   value), pop (drop the smallest) or peek (no change). The rsp channel gives
//   one word per request: the smallest value held afterwards (-1 when empty),
//   is_empty, and refused when a push found the store full.
//   Response: registered, and valid in the cycle after acceptance.
//   Throughput: one request per cycle unless a response waits; every cell
//   compares with the pushed value and shifts in the same cycle, so the row never iterates.
//   Stall: while a response waits unaccepted, req_ready stays low; it rises
//   again in the cycle the response is taken, so there is no bubble.
//   Reset: the fill count clears, the store is empty and no response is
//   pending; the cell contents are left as they are and never read until
//   written.
`default_nettype none

module sorted_min_stack #(
    parameter int DEPTH = smstk_pkg::DEPTH_DEFAULT
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire smstk_pkg::req_t   req,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output smstk_pkg::rsp_t        rsp
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                         req_fire;
    logic                         full;
    logic                         is_push;
    logic                         is_pop;
    smstk_pkg::cell_cmd_t         cmd;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         rsp_valid_reg;
    smstk_pkg::rsp_t              rsp_reg;
    smstk_pkg::rsp_t              rsp_next;

    logic                                  keep       [DEPTH];
    logic                                  occupied   [DEPTH];
    logic signed [smstk_pkg::VALUE_W-1:0]  cell_value [DEPTH];
    logic signed [smstk_pkg::VALUE_W-1:0]  cell_next  [DEPTH];

    // Handshake: take a word whenever the response register is free or draining
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign req_fire  = req_valid && req_ready;

    // Decode and broadcast the command
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign is_push = (req.func == smstk_pkg::FUNC_PUSH);
    assign is_pop  = (req.func == smstk_pkg::FUNC_POP);

    always_comb
    begin
        cmd.push  = req_fire && is_push && !full;
        cmd.pop   = req_fire && is_pop && (count_reg != '0);
        cmd.value = req.value;
    end

    // Row of cells; cell 0 sees an always-kept left neighbour
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        assign occupied[i] = (CNT_W'(i) < count_reg);

        if (i == 0)
        begin : g_first
            if (DEPTH > 1)
            begin : g_more
                smstk_cell u_cell (
                    .clk         (clk),
                    .cmd         (cmd),
                    .occupied    (occupied[i]),
                    .left_keep   (1'b1),
                    .left_value  (cmd.value),
                    .right_value (cell_value[i+1]),
                    .keep        (keep[i]),
                    .value       (cell_value[i]),
                    .value_next  (cell_next[i])
                );
            end
            else
            begin : g_single
                smstk_cell u_cell (
                    .clk         (clk),
                    .cmd         (cmd),
                    .occupied    (occupied[i]),
                    .left_keep   (1'b1),
                    .left_value  (cmd.value),
                    .right_value (cell_value[i]),
                    .keep        (keep[i]),
                    .value       (cell_value[i]),
                    .value_next  (cell_next[i])
                );
            end
        end
        else if (i == DEPTH - 1)
        begin : g_last
            smstk_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occupied[i]),
                .left_keep   (keep[i-1]),
                .left_value  (cell_value[i-1]),
                .right_value (cell_value[i]),
                .keep        (keep[i]),
                .value       (cell_value[i]),
                .value_next  (cell_next[i])
            );
        end
        else
        begin : g_mid
            smstk_cell u_cell (
                .clk         (clk),
                .cmd         (cmd),
                .occupied    (occupied[i]),
                .left_keep   (keep[i-1]),
                .left_value  (cell_value[i-1]),
                .right_value (cell_value[i+1]),
                .keep        (keep[i]),
                .value       (cell_value[i]),
                .value_next  (cell_next[i])
            );
        end
    end

    // Fill count
    always_comb
    begin
        count_next = count_reg;
        if (cmd.push)
            count_next = count_reg + CNT_W'(1);
        else if (cmd.pop)
            count_next = count_reg - CNT_W'(1);
    end

    // Response word from the state after the operation
    always_comb
    begin
        rsp_next.is_empty  = (count_next == '0);
        rsp_next.top_value = rsp_next.is_empty ? smstk_pkg::EMPTY_TOP : cell_next[0];
        rsp_next.refused   = is_push && full;
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (req_fire)
                rsp_valid_reg <= 1'b1;
            else if (rsp_ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    // Response payload
    always_ff @(posedge clk)
    begin
        if (req_fire)
            rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire
